// ===== design/p2oc_pkg.sv =====
// Package for the pixel to occupancy cell unit: register indexes, map modes,
// cell codes, reset values and the tag that travels beside the divider.
// No dependencies.
`default_nettype none

package p2oc_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned MAX_CHANNELS_DEF = 4;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_ALPHA_PRESENT = 3'd1,
    REG_MAP_MODE      = 3'd2,
    REG_INVERT_INPUT  = 3'd3,
    REG_OCC_THRESH    = 3'd4,
    REG_FREE_THRESH   = 3'd5
  } p2oc_reg_e;

  // Map modes; the fourth code behaves as raw
  typedef enum logic [1:0] {
    MODE_TRINARY = 2'd0,
    MODE_SCALE   = 2'd1,
    MODE_RAW     = 2'd2
  } p2oc_mode_e;

  // Reset values
  localparam logic [CNT_W-1:0] RST_CHANNEL_COUNT = 3'd1;
  localparam logic [15:0]      RST_OCC_THRESH    = 16'd42598;
  localparam logic [15:0]      RST_FREE_THRESH   = 16'd12845;

  // Cell codes
  localparam logic [7:0] CELL_OCCUPIED = 8'd100;
  localparam logic [7:0] CELL_FREE     = 8'd0;
  localparam logic [7:0] CELL_UNKNOWN  = 8'd255;
  localparam logic [7:0] SCALE_TOP     = 8'd99;
  localparam logic [7:0] FULL_BYTE     = 8'd255;

  // Quotient bits of the scale division (result never exceeds 99)
  localparam int unsigned DIV_STEPS = 7;

  // Reciprocal of six in Q0.18 for the three-channel raw average
  localparam logic [15:0] RECIP_SIX = 16'd43691;
  localparam int unsigned RECIP_SHIFT = 18;

  // What the divider carries beside each operand pair
  typedef struct packed {
    logic       scale;
    logic [7:0] fixed_val;
  } p2oc_tag_t;

endpackage

`default_nettype wire

// ===== design/p2oc_pix_if.sv =====
// Channel interfaces of the pixel to occupancy cell unit: pixel in, cell out.
// Both use a valid/ready handshake. No dependencies.
`default_nettype none

interface p2oc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;
  logic [7:0] chan_d;

  modport source (output valid, output chan_a, output chan_b, output chan_c,
                  output chan_d, input ready);
  modport sink   (input valid, input chan_a, input chan_b, input chan_c,
                  input chan_d, output ready);
endinterface

interface p2oc_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

`default_nettype wire

// ===== design/p2oc_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per register stage, with a
// side tag carried alongside. Depends on p2oc_pkg.
`default_nettype none

module p2oc_div_pipe #(
  parameter int unsigned XW = 34,
  parameter int unsigned YW = 27
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire  [XW-1:0]          x_i,
  input  wire  [YW-1:0]          y_i,
  input  wire  p2oc_pkg::p2oc_tag_t tag_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic [p2oc_pkg::DIV_STEPS-1:0] quot_o,
  output p2oc_pkg::p2oc_tag_t    tag_o
);
  import p2oc_pkg::*;

  localparam int unsigned NS = DIV_STEPS;

  logic [NS-1:0]  v_q;
  logic [NS-1:0]  adv;
  logic [XW-1:0]  r_q   [NS];
  logic [YW-1:0]  y_q   [NS];
  logic [NS-1:0]  quo_q [NS];
  p2oc_tag_t      tag_q [NS];

  // Advance a stage when it is empty or its successor takes its item
  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
  end

  assign in_ready_o = adv[0];

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam int unsigned SH = NS - 1 - i;

    logic [XW-1:0] r_in;
    logic [YW-1:0] y_in;
    logic [NS-1:0] quo_in;
    p2oc_tag_t     tag_in;
    logic          v_in;
    logic [XW-1:0] ysh;
    logic          take;
    logic [XW-1:0] r_d;
    logic [NS-1:0] quo_d;

    if (i == 0) begin : g_first
      assign r_in   = x_i;
      assign y_in   = y_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
      assign v_in   = in_valid_i;
    end else begin : g_next
      assign r_in   = r_q[i-1];
      assign y_in   = y_q[i-1];
      assign quo_in = quo_q[i-1];
      assign tag_in = tag_q[i-1];
      assign v_in   = v_q[i-1];
    end

    // Try to subtract the divisor shifted to this quotient bit
    always_comb begin
      ysh   = XW'(y_in) << SH;
      take  = (r_in >= ysh);
      r_d   = take ? (r_in - ysh) : r_in;
      quo_d = {quo_in[NS-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (adv[i]) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[i]) begin
        r_q[i]   <= r_d;
        y_q[i]   <= y_in;
        quo_q[i] <= quo_d;
        tag_q[i] <= tag_in;
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign quot_o      = quo_q[NS-1];
  assign tag_o       = tag_q[NS-1];

endmodule

`default_nettype wire

// ===== design/pixel_to_occupancy_cell_unit.sv =====
// Pixel to occupancy cell unit: top level with configuration registers and the
// front pipeline, feeding p2oc_div_pipe. Depends on p2oc_pkg and the interfaces.
`default_nettype none

// Converts one pixel of up to four channel bytes into one occupancy-grid cell
// byte per transfer. The unit is a pipeline of eleven register stages: four
// front stages (channel sum, threshold products, classification, scale
// operands) followed by seven stages of a restoring divider that produce the
// scale quotient one bit per stage. A pixel may be accepted in every cycle
// while the cell output is not stalled, so the sustained rate is one pixel per
// clock. The cell value is driven from the last divider stage register. Each
// stage holds while its successor is full and stalled, so back-pressure on the
// cell output propagates stage by stage and empty stages still fill.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// and must only change while the pipeline holds no items.

module pixel_to_occupancy_cell_unit #(
  parameter int unsigned MAX_CHANNELS = p2oc_pkg::MAX_CHANNELS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [p2oc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [p2oc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  p2oc_pix_if.sink                         pix_i,
  p2oc_cell_if.source                      cell_o
);
  import p2oc_pkg::*;

  localparam int unsigned SUM_W = $clog2(255 * MAX_CHANNELS + 1);
  localparam int unsigned LHS_W = SUM_W + 16;
  localparam int unsigned RX_W  = SUM_W + 2;
  localparam int unsigned XW    = LHS_W + 9;
  localparam int unsigned YW    = LHS_W + 1;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_CHANNELS);

  // ---------------- configuration registers ----------------
  logic [CNT_W-1:0] cfg_count_q;
  logic             cfg_alpha_q;
  logic [1:0]       cfg_mode_q;
  logic             cfg_inv_q;
  logic [15:0]      cfg_occ_q;
  logic [15:0]      cfg_free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= RST_CHANNEL_COUNT;
      cfg_alpha_q <= 1'b0;
      cfg_mode_q  <= MODE_TRINARY;
      cfg_inv_q   <= 1'b0;
      cfg_occ_q   <= RST_OCC_THRESH;
      cfg_free_q  <= RST_FREE_THRESH;
    end else if (cfg_we_i) begin
      case (p2oc_reg_e'(cfg_idx_i))
        REG_CHANNEL_COUNT: cfg_count_q <= cfg_data_i[CNT_W-1:0];
        REG_ALPHA_PRESENT: cfg_alpha_q <= cfg_data_i[0];
        REG_MAP_MODE:      cfg_mode_q  <= cfg_data_i[1:0];
        REG_INVERT_INPUT:  cfg_inv_q   <= cfg_data_i[0];
        REG_OCC_THRESH:    cfg_occ_q   <= cfg_data_i[15:0];
        REG_FREE_THRESH:   cfg_free_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic mode_raw;
  assign mode_raw = (cfg_mode_q != MODE_TRINARY) && (cfg_mode_q != MODE_SCALE);

  // ---------------- stage handshake ----------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic adv1, adv2, adv3, adv4;
  logic div_ready;

  assign adv4 = !s4_v_q || div_ready;
  assign adv3 = !s3_v_q || adv4;
  assign adv2 = !s2_v_q || adv3;
  assign adv1 = !s1_v_q || adv2;
  assign pix_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q <= pix_i.valid;
      if (adv2) s2_v_q <= s1_v_q;
      if (adv3) s3_v_q <= s2_v_q;
      if (adv4) s4_v_q <= s3_v_q;
    end
  end

  // ---------------- stage 1: channel sum and alpha ----------------
  logic [7:0]       chan [4];
  logic [CNT_W-1:0] n_c;
  logic [CNT_W-1:0] m_c;
  logic [SUM_W-1:0] sum_c;
  logic [SUM_W-1:0] full_c;
  logic [1:0]       alpha_idx;
  logic             alpha_zero_c;
  logic [SUM_W-1:0] s1_adj_d;

  assign chan[0] = pix_i.chan_a;
  assign chan[1] = pix_i.chan_b;
  assign chan[2] = pix_i.chan_c;
  assign chan[3] = pix_i.chan_d;

  always_comb begin
    // Clamp the channel count into 1..MAX_CHANNELS
    if (cfg_count_q == '0) begin
      n_c = CNT_W'(1);
    end else if (cfg_count_q > MAX_N) begin
      n_c = MAX_N;
    end else begin
      n_c = cfg_count_q;
    end
    // Drop the alpha channel from the average outside trinary mode
    if ((cfg_mode_q != MODE_TRINARY) && cfg_alpha_q && (n_c >= CNT_W'(2))) begin
      m_c = n_c - CNT_W'(1);
    end else begin
      m_c = n_c;
    end
    sum_c = '0;
    for (int k = 0; k < 4; k++) begin
      if (CNT_W'(k) < m_c) begin
        sum_c = sum_c + SUM_W'(chan[k]);
      end
    end
    alpha_idx    = 2'(n_c - CNT_W'(1));
    alpha_zero_c = (n_c != CNT_W'(1)) && (chan[alpha_idx] == 8'd0);
    full_c       = (SUM_W'(m_c) << 8) - SUM_W'(m_c);
    s1_adj_d     = cfg_inv_q ? (full_c - sum_c) : sum_c;
  end

  logic [SUM_W-1:0] s1_adj_q;
  logic [CNT_W-1:0] s1_m_q;
  logic             s1_az_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_adj_q <= s1_adj_d;
      s1_m_q   <= m_c;
      s1_az_q  <= alpha_zero_c;
    end
  end

  // ---------------- stage 2: threshold products and raw average ----------------
  logic [SUM_W-1:0]    d_c;
  logic [SUM_W-1:0]    p_c;
  logic [LHS_W-1:0]    s2_lhs_d;
  logic [LHS_W-1:0]    s2_tod_d;
  logic [LHS_W-1:0]    s2_tfd_d;
  logic [RX_W-1:0]     rx_c;
  logic [RX_W+15:0]    rprod_c;
  logic [7:0]          s2_raw_d;

  always_comb begin
    d_c      = (SUM_W'(s1_m_q) << 8) - SUM_W'(s1_m_q);
    p_c      = d_c - s1_adj_q;
    s2_lhs_d = {p_c, 16'd0};
    s2_tod_d = LHS_W'(cfg_occ_q) * LHS_W'(d_c);
    s2_tfd_d = LHS_W'(cfg_free_q) * LHS_W'(d_c);
    // Round half up of adj / m, i.e. floor((2 adj + m) / (2 m))
    rx_c     = (RX_W'(s1_adj_q) << 1) + RX_W'(s1_m_q);
    rprod_c  = (RX_W + 16)'(rx_c) * (RX_W + 16)'(RECIP_SIX);
    case (s1_m_q)
      3'd1:    s2_raw_d = 8'(rx_c >> 1);
      3'd2:    s2_raw_d = 8'(rx_c >> 2);
      3'd4:    s2_raw_d = 8'(rx_c >> 3);
      default: s2_raw_d = 8'(rprod_c >> RECIP_SHIFT);
    endcase
  end

  logic [LHS_W-1:0] s2_lhs_q;
  logic [LHS_W-1:0] s2_tod_q;
  logic [LHS_W-1:0] s2_tfd_q;
  logic [7:0]       s2_raw_q;
  logic             s2_az_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_lhs_q <= s2_lhs_d;
      s2_tod_q <= s2_tod_d;
      s2_tfd_q <= s2_tfd_d;
      s2_raw_q <= s2_raw_d;
      s2_az_q  <= s1_az_q;
    end
  end

  // ---------------- stage 3: classify and form the scale operands ----------------
  p2oc_tag_t        s3_tag_d;
  logic [LHS_W-1:0] s3_num_d;
  logic [LHS_W-1:0] s3_den_d;

  always_comb begin
    s3_tag_d.scale     = 1'b0;
    s3_tag_d.fixed_val = CELL_FREE;
    if (mode_raw) begin
      s3_tag_d.fixed_val = s2_raw_q;
    end else if (s2_lhs_q > s2_tod_q) begin
      s3_tag_d.fixed_val = CELL_OCCUPIED;
    end else if (s2_lhs_q < s2_tfd_q) begin
      s3_tag_d.fixed_val = CELL_FREE;
    end else if ((cfg_mode_q == MODE_TRINARY) || s2_az_q) begin
      s3_tag_d.fixed_val = CELL_UNKNOWN;
    end else if (cfg_occ_q <= cfg_free_q) begin
      s3_tag_d.fixed_val = CELL_FREE;
    end else begin
      s3_tag_d.scale = 1'b1;
    end
    s3_num_d = s2_lhs_q - s2_tfd_q;
    s3_den_d = s2_tod_q - s2_tfd_q;
  end

  p2oc_tag_t        s3_tag_q;
  logic [LHS_W-1:0] s3_num_q;
  logic [LHS_W-1:0] s3_den_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      s3_tag_q <= s3_tag_d;
      s3_num_q <= s3_num_d;
      s3_den_q <= s3_den_d;
    end
  end

  // ---------------- stage 4: dividend 198 num + den, divisor 2 den ----------------
  logic [XW-1:0] s4_x_d;
  logic [YW-1:0] s4_y_d;

  assign s4_x_d = XW'(s3_num_q) * XW'(2 * SCALE_TOP) + XW'(s3_den_q);
  assign s4_y_d = YW'(s3_den_q) << 1;

  p2oc_tag_t     s4_tag_q;
  logic [XW-1:0] s4_x_q;
  logic [YW-1:0] s4_y_q;

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      s4_tag_q <= s3_tag_q;
      s4_x_q   <= s4_x_d;
      s4_y_q   <= s4_y_d;
    end
  end

  // ---------------- divider and output select ----------------
  logic [DIV_STEPS-1:0] quot;
  p2oc_tag_t            out_tag;

  p2oc_div_pipe #(
    .XW (XW),
    .YW (YW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s4_v_q),
    .in_ready_o  (div_ready),
    .x_i         (s4_x_q),
    .y_i         (s4_y_q),
    .tag_i       (s4_tag_q),
    .out_valid_o (cell_o.valid),
    .out_ready_i (cell_o.ready),
    .quot_o      (quot),
    .tag_o       (out_tag)
  );

  // Pass the fixed value, or clamp the scale quotient to the top of the scale range
  always_comb begin
    if (!out_tag.scale) begin
      cell_o.cell_value = out_tag.fixed_val;
    end else if (8'(quot) > SCALE_TOP) begin
      cell_o.cell_value = SCALE_TOP;
    end else begin
      cell_o.cell_value = 8'(quot);
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/p2oc_cell_checker.sv =====
`timescale 1ns / 1ps
// Cell checker for the pixel to occupancy cell unit: tracks the register writes,
// predicts one cell per pixel transfer and compares the cell transfers in order.
// Depends on p2oc_pkg and the channel interfaces.

module p2oc_cell_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [p2oc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [p2oc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  p2oc_pix_if                               pix_mon,
  p2oc_cell_if                              cell_mon,
  output int                                fail_count_o,
  output int                                cells_pending_o
);
  import p2oc_pkg::*;

  // Shadow copy of the configuration registers
  logic [CNT_W-1:0] cnt_q;
  logic             alpha_q;
  logic [1:0]       mode_q;
  logic             inv_q;
  logic [15:0]      occ_q;
  logic [15:0]      free_q;

  logic [7:0] cell_expect_q [$];
  int         fail_total;

  // Work out the cell byte for one pixel under the current settings
  function automatic logic [7:0] predict_cell(input logic [3:0][7:0] chans);
    int unsigned     n, m, k, total, alpha_byte, level;
    longint unsigned span, occupancy, lhs, num, den, cell_val;
    n = (cnt_q == 0) ? 1 : cnt_q;
    if (n > MAX_CHANNELS_DEF) n = MAX_CHANNELS_DEF;
    // alpha leaves the average outside trinary mode
    m = n;
    if (mode_q != MODE_TRINARY && alpha_q && n >= 2) m = n - 1;
    total = 0;
    for (k = 0; k < m; k++) total += chans[k];
    alpha_byte = (n == 1) ? 255 : chans[n-1];
    level = inv_q ? 255 * m - total : total;
    // raw and the spare code: rounded average
    if (mode_q >= MODE_RAW) begin
      cell_val = (2 * level + m) / (2 * m);
      if (cell_val > FULL_BYTE) cell_val = FULL_BYTE;
      return cell_val[7:0];
    end
    span = 255 * m;
    occupancy = span - level;
    lhs = occupancy << 16;
    if (lhs > occ_q * span) begin
      cell_val = CELL_OCCUPIED;
    end else if (lhs < free_q * span) begin
      cell_val = CELL_FREE;
    end else if (mode_q == MODE_TRINARY || alpha_byte == 0) begin
      cell_val = CELL_UNKNOWN;
    end else if (occ_q <= free_q) begin
      cell_val = 0;
    end else begin
      num = lhs - free_q * span;
      den = (occ_q - free_q) * span;
      cell_val = (2 * SCALE_TOP * num + den) / (2 * den);
      if (cell_val > SCALE_TOP) cell_val = SCALE_TOP;
    end
    return cell_val[7:0];
  endfunction

  function automatic void log_failure(input string what);
    fail_total++;
    if (fail_total <= 10) $display("%t: %s", $realtime, what);
  endfunction

  // Follow the register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= RST_CHANNEL_COUNT;
      alpha_q <= 1'b0;
      mode_q  <= MODE_TRINARY;
      inv_q   <= 1'b0;
      occ_q   <= RST_OCC_THRESH;
      free_q  <= RST_FREE_THRESH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CHANNEL_COUNT: cnt_q   <= cfg_data_i[CNT_W-1:0];
        REG_ALPHA_PRESENT: alpha_q <= cfg_data_i[0];
        REG_MAP_MODE:      mode_q  <= cfg_data_i[1:0];
        REG_INVERT_INPUT:  inv_q   <= cfg_data_i[0];
        REG_OCC_THRESH:    occ_q   <= cfg_data_i;
        REG_FREE_THRESH:   free_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Queue a prediction per pixel transfer, compare each cell transfer
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (pix_mon.valid && pix_mon.ready) begin
      cell_expect_q.push_back(predict_cell({pix_mon.chan_d, pix_mon.chan_c,
                                            pix_mon.chan_b, pix_mon.chan_a}));
    end
    if (cell_mon.valid && cell_mon.ready) begin
      if (cell_expect_q.size() == 0) begin
        log_failure($sformatf("unexpected cell %0d with no pixel outstanding",
                              cell_mon.cell_value));
      end else begin
        want = cell_expect_q.pop_front();
        if (cell_mon.cell_value !== want)
          log_failure($sformatf("cell mismatch: expected %0d, got %0d",
                                want, cell_mon.cell_value));
      end
    end
    fail_count_o    <= fail_total;
    cells_pending_o <= cell_expect_q.size();
  end

endmodule

// ===== tb/sv/pixel_to_occupancy_cell_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the pixel to occupancy cell unit: clock, reset, register
// programming, pixel and cell handshakes, and the verdict.
// Depends on p2oc_pkg, the channel interfaces and p2oc_cell_checker.

module pixel_to_occupancy_cell_unit_test;
  import p2oc_pkg::*;

  localparam int unsigned RANDOM_PIXELS    = 600;
  localparam int unsigned LONG_HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES    = 20;
  // fourth map code, decodes as raw
  localparam logic [1:0]  MODE_SPARE       = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  p2oc_pix_if  pix_bus ();
  p2oc_cell_if cell_bus ();

  int fail_count;
  int cells_pending;
  bit pix_steady;
  bit cell_steady;
  bit hold_cells_due;

  pixel_to_occupancy_cell_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_bus),
    .cell_o     (cell_bus)
  );

  p2oc_cell_checker i_cell_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .pix_mon         (pix_bus),
    .cell_mon        (cell_bus),
    .fail_count_o    (fail_count),
    .cells_pending_o (cells_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Cell side: random stall per transfer, steady stretches, one long hold-off
  initial begin
    int gap;
    cell_bus.ready <= 1'b0;
    forever begin
      if (hold_cells_due) begin
        hold_cells_due = 1'b0;
        cell_bus.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end
      if ($urandom_range(0, 39) == 0) cell_steady = !cell_steady;
      gap = cell_steady ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        cell_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      cell_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!cell_bus.valid);
    end
  end

  // Offer one pixel after a random gap (none while steady); valid stays high after the transfer
  task automatic send_pixel(input logic [7:0] a, b, c, d);
    int gap;
    gap = pix_steady ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_bus.valid  <= 1'b1;
    pix_bus.chan_a <= a;
    pix_bus.chan_b <= b;
    pix_bus.chan_c <= c;
    pix_bus.chan_d <= d;
    do @(posedge clk_i); while (!pix_bus.ready);
  endtask

  // Drop valid and hold until every predicted cell has come out
  task automatic wait_idle();
    pix_bus.valid <= 1'b0;
    do @(posedge clk_i); while (cells_pending != 0);
  endtask

  task automatic put_reg(input p2oc_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CNT_W-1:0] cnt, input logic alpha,
                              input logic [1:0] mode, input logic inv,
                              input logic [15:0] occ, input logic [15:0] free);
    put_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(cnt));
    put_reg(REG_ALPHA_PRESENT, CFG_DATA_W'(alpha));
    put_reg(REG_MAP_MODE,      CFG_DATA_W'(mode));
    put_reg(REG_INVERT_INPUT,  CFG_DATA_W'(inv));
    put_reg(REG_OCC_THRESH,    occ);
    put_reg(REG_FREE_THRESH,   free);
    cfg_we <= 1'b0;
  endtask

  // Bias towards the byte extremes
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Reset, directed pixels, then random phases
  initial begin
    int             sent;
    int             batch;
    bit             first_phase;
    logic [CNT_W-1:0] cnt;
    logic [1:0]     mode;
    logic [15:0]    occ, free, tmp;

    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_CHANNEL_COUNT;
    cfg_data       <= '0;
    pix_bus.valid  <= 1'b0;
    pix_bus.chan_a <= '0;
    pix_bus.chan_b <= '0;
    pix_bus.chan_c <= '0;
    pix_bus.chan_d <= '0;
    pix_steady     = 1'b0;
    cell_steady    = 1'b0;
    hold_cells_due = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one channel, trinary
    send_pixel(8'd0, 8'd17, 8'd34, 8'd51);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd128, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd77, 8'd1, 8'd2, 8'd3);

    // Four channels with alpha, full-range scale; alpha zero gives unknown
    wait_idle();
    program_regs(3'd4, 1'b1, MODE_SCALE, 1'b0, 16'hFFFF, 16'h0000);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd100, 8'd50, 8'd200, 8'd0);
    send_pixel(8'd128, 8'd128, 8'd128, 8'd1);

    // Equal thresholds in scale mode
    wait_idle();
    program_regs(3'd2, 1'b1, MODE_SCALE, 1'b0, 16'd30000, 16'd30000);
    send_pixel(8'd128, 8'd200, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd255);

    // Channel count zero acts as one; spare map code acts as raw; inverted
    wait_idle();
    program_regs(3'd0, 1'b1, MODE_SPARE, 1'b1, 16'd42598, 16'd12845);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd3, 8'd9, 8'd9, 8'd9);

    // Channel count above four acts as four; alpha byte still read; inverted
    wait_idle();
    program_regs(3'd7, 1'b0, MODE_TRINARY, 1'b1, 16'h0000, 16'hFFFF);
    send_pixel(8'd1, 8'd2, 8'd3, 8'd4);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd0);

    // Three-channel raw rounding
    wait_idle();
    program_regs(3'd3, 1'b0, MODE_RAW, 1'b0, 16'd42598, 16'd12845);
    send_pixel(8'd1, 8'd0, 8'd0, 8'd99);
    send_pixel(8'd2, 8'd0, 8'd0, 8'd99);
    send_pixel(8'd255, 8'd255, 8'd254, 8'd0);

    // Alpha flag with one channel: treated as opaque
    wait_idle();
    program_regs(3'd1, 1'b1, MODE_SCALE, 1'b0, 16'd42598, 16'd12845);
    send_pixel(8'd128, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd0);

    // Random phases: new settings once the unit is empty, then a batch
    sent = 0;
    first_phase = 1'b1;
    while (sent < RANDOM_PIXELS) begin
      wait_idle();
      cnt = ($urandom_range(0, 5) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(1, 4));
      case ($urandom_range(0, 7))
        0, 1:    mode = MODE_TRINARY;
        2, 3, 4: mode = MODE_SCALE;
        5, 6:    mode = MODE_RAW;
        default: mode = MODE_SPARE;
      endcase
      occ  = 16'($urandom);
      free = 16'($urandom);
      case ($urandom_range(0, 5))
        0: begin occ = 16'hFFFF; free = 16'h0000; end
        1: free = occ;
        2, 3: if (occ < free) begin tmp = occ; occ = free; free = tmp; end
        4: ;
        default: begin occ = 16'h0000; free = 16'hFFFF; end
      endcase
      program_regs(cnt, 1'($urandom), mode, 1'($urandom), occ, free);

      // First phase: keep offering pixels while the cell side holds off
      if (first_phase) begin
        pix_steady     = 1'b1;
        hold_cells_due = 1'b1;
        batch          = 60;
      end else begin
        batch = $urandom_range(20, 60);
      end
      repeat (batch) begin
        if (!first_phase && $urandom_range(0, 39) == 0) pix_steady = !pix_steady;
        send_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte());
      end
      sent += batch;
      if (first_phase) pix_steady = 1'b0;
      first_phase = 1'b0;
    end

    // Drain, let the pipeline settle, then give the verdict
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && cells_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
